### hw/rtl/trac_pkg.sv
package trac_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_TEMP = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BOUND = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_BEEP_HALF  = 2'd0;
    localparam logic [1:0] CFG_SNOOZE     = 2'd1;
    localparam logic [1:0] CFG_ERROR_HOLD = 2'd2;
    localparam logic [1:0] CFG_MAX_BOUND  = 2'd3;

    // Key codes out of the keypad map
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_NONE      = 4'd10;
    localparam logic [3:0] KEY_C         = 4'd12;
    localparam logic [3:0] KEY_D         = 4'd13;

    // Sizes
    localparam int TIMER_BITS       = 16;
    localparam int DIGITS_PER_BOUND = 2;
    localparam int TOTAL_DIGITS     = 2 * DIGITS_PER_BOUND;
    localparam int CFG_BITS         = 16;
    localparam int BEEP_BITS        = CFG_BITS + 1;
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // Reset values
    localparam logic [15:0] RST_BEEP_HALF  = 16'd50;
    localparam logic [15:0] RST_SNOOZE     = 16'd6000;
    localparam logic [15:0] RST_ERROR_HOLD = 16'd500;
    localparam logic [6:0]  RST_MAX_BOUND  = 7'd50;
    localparam logic [6:0]  RST_BOUND_LOW  = 7'd10;
    localparam logic [6:0]  RST_BOUND_HIGH = 7'd35;
    localparam logic [6:0]  RST_TEMP       = 7'd25;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] key_row;
        logic [1:0] key_col;
        logic [6:0] temperature;
    } in_t;

    typedef struct packed {
        logic       buzzer_on;
        logic [6:0] range_low;
        logic [6:0] range_high;
        logic       entering;
        logic [1:0] digits_entered;
        logic [1:0] error_code;
        logic       error_showing;
        logic       snoozed;
        logic       out_of_range;
        logic [6:0] temp_shown;
    } out_t;

    typedef struct packed {
        logic [15:0] beep_half_ticks;
        logic [15:0] snooze_ticks;
        logic [15:0] error_hold_ticks;
        logic [6:0]  max_bound;
    } cfg_t;

    // Map a keypad position to a digit or a key code
    function automatic logic [3:0] key_code(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] code;
        case ({row, col})
            4'b00_00: code = 4'd1;
            4'b00_01: code = 4'd2;
            4'b00_10: code = 4'd3;
            4'b01_00: code = 4'd4;
            4'b01_01: code = 4'd5;
            4'b01_10: code = 4'd6;
            4'b10_00: code = 4'd7;
            4'b10_01: code = 4'd8;
            4'b10_10: code = 4'd9;
            4'b10_11: code = KEY_C;
            4'b11_01: code = 4'd0;
            4'b11_11: code = KEY_D;
            default:  code = KEY_NONE;
        endcase
        return code;
    endfunction

    // Clamp a loaded value to the timer range
    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CFG_BITS-1:0] v);
        logic [TIMER_BITS-1:0] r;
        if ({17'd0, v} > TIMER_MAX) begin
            r = TIMER_MAX[TIMER_BITS-1:0];
        end else begin
            r = TIMER_BITS'(v);
        end
        return r;
    endfunction

endpackage

### hw/rtl/trac_core.sv
module trac_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  trac_pkg::in_t   item,
    input  trac_pkg::cfg_t  cfg,
    output trac_pkg::out_t  result
);

    logic [6:0]                      bound_low_reg, bound_low_next;
    logic [6:0]                      bound_high_reg, bound_high_next;
    logic                            entry_active_reg, entry_active_next;
    logic [1:0]                      digit_count_reg, digit_count_next;
    logic [6:0]                      pending_low_reg, pending_low_next;
    logic [6:0]                      pending_high_reg, pending_high_next;
    logic [1:0]                      error_kind_reg, error_kind_next;
    logic [trac_pkg::TIMER_BITS-1:0] error_timer_reg, error_timer_next;
    logic                            snooze_request_reg, snooze_request_next;
    logic [trac_pkg::TIMER_BITS-1:0] snooze_timer_reg, snooze_timer_next;
    logic [trac_pkg::BEEP_BITS-1:0]  beep_timer_reg, beep_timer_next;
    logic                            beep_running_reg, beep_running_next;
    logic [6:0]                      last_temp_reg, last_temp_next;

    logic [3:0] key;
    logic       outside;
    logic       start_beep;

    assign key = trac_pkg::key_code(item.key_row, item.key_col);

    // Apply one item, then check for a beep cycle boundary
    always_comb begin
        bound_low_next      = bound_low_reg;
        bound_high_next     = bound_high_reg;
        entry_active_next   = entry_active_reg;
        digit_count_next    = digit_count_reg;
        pending_low_next    = pending_low_reg;
        pending_high_next   = pending_high_reg;
        error_kind_next     = error_kind_reg;
        error_timer_next    = error_timer_reg;
        snooze_request_next = snooze_request_reg;
        snooze_timer_next   = snooze_timer_reg;
        beep_timer_next     = beep_timer_reg;
        beep_running_next   = beep_running_reg;
        last_temp_next      = last_temp_reg;
        outside             = 1'b0;
        start_beep          = 1'b0;

        case (item.kind)
            trac_pkg::KIND_TICK: begin
                if (error_timer_reg != '0) begin
                    error_timer_next = error_timer_reg - 1'b1;
                    if (error_timer_next == '0) begin
                        error_kind_next = trac_pkg::ERR_NONE;
                    end
                end
                if (snooze_timer_reg != '0) begin
                    snooze_timer_next = snooze_timer_reg - 1'b1;
                    if (snooze_timer_next == '0) begin
                        snooze_request_next = 1'b0;
                    end
                end else if (beep_running_reg) begin
                    beep_timer_next = beep_timer_reg + 1'b1;
                    if (beep_timer_next >= {cfg.beep_half_ticks, 1'b0}) begin
                        beep_running_next = 1'b0;
                    end
                end
            end
            trac_pkg::KIND_KEY: begin
                if (entry_active_reg) begin
                    // Take a digit, ignore everything else
                    if (key <= trac_pkg::KEY_DIGIT_MAX) begin
                        if (32'(digit_count_reg) < trac_pkg::DIGITS_PER_BOUND) begin
                            pending_low_next = (pending_low_reg << 3) + (pending_low_reg << 1)
                                + {3'd0, key};
                        end else begin
                            pending_high_next = (pending_high_reg << 3)
                                + (pending_high_reg << 1) + {3'd0, key};
                        end
                        if (32'(digit_count_reg) + 1 < trac_pkg::TOTAL_DIGITS) begin
                            digit_count_next = digit_count_reg + 2'd1;
                        end else begin
                            entry_active_next = 1'b0;
                            digit_count_next  = 2'd0;
                            if (pending_high_next > cfg.max_bound
                                    || pending_low_next > cfg.max_bound) begin
                                error_kind_next  = trac_pkg::ERR_BOUND;
                                error_timer_next = trac_pkg::sat_load(cfg.error_hold_ticks);
                            end else if (pending_low_next >= pending_high_next) begin
                                error_kind_next  = trac_pkg::ERR_ORDER;
                                error_timer_next = trac_pkg::sat_load(cfg.error_hold_ticks);
                            end else begin
                                bound_low_next      = pending_low_next;
                                bound_high_next     = pending_high_next;
                                snooze_request_next = 1'b0;
                                error_kind_next     = trac_pkg::ERR_NONE;
                                error_timer_next    = '0;
                            end
                            if (error_timer_next == '0) begin
                                error_kind_next = trac_pkg::ERR_NONE;
                            end
                        end
                    end
                end else if (key == trac_pkg::KEY_D) begin
                    entry_active_next = 1'b1;
                    digit_count_next  = 2'd0;
                    pending_low_next  = 7'd0;
                    pending_high_next = 7'd0;
                    error_kind_next   = trac_pkg::ERR_NONE;
                    error_timer_next  = '0;
                end else if (key == trac_pkg::KEY_C && beep_running_reg
                        && beep_timer_reg < {1'b0, cfg.beep_half_ticks}) begin
                    snooze_request_next = 1'b1;
                end
            end
            trac_pkg::KIND_TEMP: begin
                last_temp_next = item.temperature;
            end
            default: begin
            end
        endcase

        // Start a snooze or a beep cycle at a boundary
        outside = (last_temp_next < bound_low_next) || (last_temp_next > bound_high_next);
        if (!beep_running_next && snooze_timer_next == '0 && outside) begin
            start_beep = 1'b1;
            if (snooze_request_next) begin
                snooze_timer_next = trac_pkg::sat_load(cfg.snooze_ticks);
                if (snooze_timer_next != '0) begin
                    start_beep = 1'b0;
                end else begin
                    snooze_request_next = 1'b0;
                end
            end
            if (start_beep) begin
                beep_running_next = 1'b1;
                beep_timer_next   = '0;
            end
        end

        result.buzzer_on      = beep_running_next
            && (beep_timer_next < {1'b0, cfg.beep_half_ticks});
        result.range_low      = bound_low_next;
        result.range_high     = bound_high_next;
        result.entering       = entry_active_next;
        result.digits_entered = digit_count_next;
        result.error_code     = error_kind_next;
        result.error_showing  = (error_timer_next != '0);
        result.snoozed        = (snooze_timer_next != '0);
        result.out_of_range   = outside;
        result.temp_shown     = last_temp_next;
    end

    // Hold state, advance on each item taken from the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_low_reg      <= trac_pkg::RST_BOUND_LOW;
            bound_high_reg     <= trac_pkg::RST_BOUND_HIGH;
            entry_active_reg   <= 1'b0;
            digit_count_reg    <= 2'd0;
            pending_low_reg    <= 7'd0;
            pending_high_reg   <= 7'd0;
            error_kind_reg     <= trac_pkg::ERR_NONE;
            error_timer_reg    <= '0;
            snooze_request_reg <= 1'b0;
            snooze_timer_reg   <= '0;
            beep_timer_reg     <= '0;
            beep_running_reg   <= 1'b0;
            last_temp_reg      <= trac_pkg::RST_TEMP;
        end else if (advance) begin
            bound_low_reg      <= bound_low_next;
            bound_high_reg     <= bound_high_next;
            entry_active_reg   <= entry_active_next;
            digit_count_reg    <= digit_count_next;
            pending_low_reg    <= pending_low_next;
            pending_high_reg   <= pending_high_next;
            error_kind_reg     <= error_kind_next;
            error_timer_reg    <= error_timer_next;
            snooze_request_reg <= snooze_request_next;
            snooze_timer_reg   <= snooze_timer_next;
            beep_timer_reg     <= beep_timer_next;
            beep_running_reg   <= beep_running_next;
            last_temp_reg      <= last_temp_next;
        end
    end

endmodule

### hw/rtl/temp_range_alarm_controller_unit.sv
// Channel   Ports                              Word
// input     s_valid s_ready s_data             trac_pkg::in_t
// result    m_valid m_ready m_data             trac_pkg::out_t
// config    cfg_valid cfg_ready cfg_index/data index 0..3, 16-bit data
//
// One result word per input word. A word waits in the input register and is
// evaluated there against the state in the core; its result lands in the
// output register, and one word can be taken every cycle while m_ready is
// high. Reset is synchronous and active low and loads the default range and
// timings. While the output register is full and m_ready is low, the input
// register still takes one more word.
module temp_range_alarm_controller_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  trac_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output trac_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    logic            in_valid_reg;
    trac_pkg::in_t   in_data_reg;
    logic            out_valid_reg;
    trac_pkg::out_t  out_data_reg;
    trac_pkg::cfg_t  cfg_reg;
    trac_pkg::out_t  result;
    logic            advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beep_half_ticks  <= trac_pkg::RST_BEEP_HALF;
            cfg_reg.snooze_ticks     <= trac_pkg::RST_SNOOZE;
            cfg_reg.error_hold_ticks <= trac_pkg::RST_ERROR_HOLD;
            cfg_reg.max_bound        <= trac_pkg::RST_MAX_BOUND;
        end else if (cfg_valid) begin
            case (cfg_index)
                trac_pkg::CFG_BEEP_HALF:  cfg_reg.beep_half_ticks  <= cfg_data;
                trac_pkg::CFG_SNOOZE:     cfg_reg.snooze_ticks     <= cfg_data;
                trac_pkg::CFG_ERROR_HOLD: cfg_reg.error_hold_ticks <= cfg_data;
                trac_pkg::CFG_MAX_BOUND:  cfg_reg.max_bound        <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Capture input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    trac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Load result word, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    a_error_code_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.error_code == trac_pkg::ERR_NONE || m_data.error_showing))
        else $error("error code without hold time");

    a_buzzer_not_snoozed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.buzzer_on) |-> !m_data.snoozed)
        else $error("buzzer sounds during snooze");

    a_entry_clears_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.entering) |-> !m_data.error_showing)
        else $error("error shown during entry");

    a_digits_only_entering: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.digits_entered != 2'd0) |-> m_data.entering)
        else $error("digit count outside entry");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input word lost while stalled");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DIRECTED_ROWS  = 25;
    localparam int PHASES         = 5;
    localparam int PHASE_WORDS    = 175;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int STALL_LIMIT    = 1000;

    // Views that can be read straight off the defaults (range 10..35, temp 25)
    localparam trac_pkg::out_t RESET_VIEW =
        '{1'b0, 7'd10, 7'd35, 1'b0, 2'd0, trac_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0, 7'd25};
    localparam trac_pkg::out_t KEYING_VIEW =
        '{1'b0, 7'd10, 7'd35, 1'b1, 2'd0, trac_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0, 7'd25};
    localparam trac_pkg::out_t BOUND_ERR_VIEW =
        '{1'b0, 7'd10, 7'd35, 1'b0, 2'd0, trac_pkg::ERR_BOUND, 1'b1, 1'b0, 1'b0, 7'd25};
    localparam trac_pkg::out_t ORDER_ERR_VIEW =
        '{1'b0, 7'd10, 7'd35, 1'b0, 2'd0, trac_pkg::ERR_ORDER, 1'b1, 1'b0, 1'b0, 7'd25};

    typedef struct packed {
        trac_pkg::in_t  word;
        logic           typed;
        trac_pkg::out_t want;
    } plan_row_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    trac_pkg::in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    trac_pkg::out_t  m_data;
    logic  cfg_valid;
    logic  cfg_ready;
    logic  [1:0] cfg_index;
    logic  [15:0] cfg_data;

    // Expectation that travels with the word on the input channel
    logic  cur_typed;
    trac_pkg::out_t  cur_want;

    // Alarm model: configuration copy
    logic [15:0] half_ticks;
    logic [15:0] snooze_len;
    logic [15:0] hold_len;
    logic [6:0]  max_deg;

    // Alarm model: controller state
    logic [6:0]  lo_deg;
    logic [6:0]  hi_deg;
    logic        keying;
    logic [1:0]  digit_idx;
    logic [6:0]  draft_lo;
    logic [6:0]  draft_hi;
    logic [1:0]  err_code;
    logic [15:0] err_timer;
    logic        snooze_pending;
    logic [15:0] snooze_timer;
    logic [16:0] beep_phase;
    logic        beeping;
    logic [6:0]  temp_now;

    trac_pkg::out_t status_due [$];
    trac_pkg::in_t  word_backlog [$];
    plan_row_t directed_plan [DIRECTED_ROWS];
    trac_pkg::cfg_t phase_cfg [PHASES];

    bit sender_steady = 1'b0;
    bit squeeze_req   = 1'b0;
    int gen_lo = 10;
    int gen_hi = 35;

    int mismatches     = 0;
    int words_checked  = 0;
    int buzz_seen      = 0;
    int snooze_seen    = 0;
    int outside_seen   = 0;
    int bound_err_seen = 0;
    int order_err_seen = 0;
    int squeezes       = 0;
    int idle_cycles    = 0;

    temp_range_alarm_controller_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Keypad position to digit or key code
    function automatic logic [3:0] pad_code(input logic [1:0] row, input logic [1:0] col);
        logic [15:0] line;
        case (row)
            2'd0: line = {trac_pkg::KEY_NONE, 4'd3, 4'd2, 4'd1};
            2'd1: line = {trac_pkg::KEY_NONE, 4'd6, 4'd5, 4'd4};
            2'd2: line = {trac_pkg::KEY_C, 4'd9, 4'd8, 4'd7};
            default: line = {trac_pkg::KEY_D, trac_pkg::KEY_NONE, 4'd0, trac_pkg::KEY_NONE};
        endcase
        return line[col*4 +: 4];
    endfunction

    function automatic logic buzzing();
        return beeping && (beep_phase < {1'b0, half_ticks});
    endfunction

    function automatic logic temp_outside();
        return (temp_now < lo_deg) || (temp_now > hi_deg);
    endfunction

    task automatic status_reset();
        half_ticks     = 16'd50;
        snooze_len     = 16'd6000;
        hold_len       = 16'd500;
        max_deg        = 7'd50;
        lo_deg         = 7'd10;
        hi_deg         = 7'd35;
        keying         = 1'b0;
        digit_idx      = 2'd0;
        draft_lo       = 7'd0;
        draft_hi       = 7'd0;
        err_code       = trac_pkg::ERR_NONE;
        err_timer      = 16'd0;
        snooze_pending = 1'b0;
        snooze_timer   = 16'd0;
        beep_phase     = 17'd0;
        beeping        = 1'b0;
        temp_now       = 7'd25;
    endtask

    // Advance the alarm state by one word and return the status it leaves.
    // Timers are as wide as the registers, so a load never saturates.
    function automatic trac_pkg::out_t predict_status(input trac_pkg::in_t w);
        logic [3:0]     k;
        logic           started;
        trac_pkg::out_t r;
        case (w.kind)
            trac_pkg::KIND_TICK: begin
                if (err_timer != 0) begin
                    err_timer--;
                    if (err_timer == 0) err_code = trac_pkg::ERR_NONE;
                end
                if (snooze_timer != 0) begin
                    snooze_timer--;
                    if (snooze_timer == 0) snooze_pending = 1'b0;
                end else if (beeping) begin
                    beep_phase++;
                    if (beep_phase >= {half_ticks, 1'b0}) beeping = 1'b0;
                end
            end
            trac_pkg::KIND_KEY: begin
                k = pad_code(w.key_row, w.key_col);
                if (keying) begin
                    if (k <= trac_pkg::KEY_DIGIT_MAX) begin
                        if (digit_idx < trac_pkg::DIGITS_PER_BOUND) begin
                            draft_lo = 7'(draft_lo * 10 + k);
                        end else begin
                            draft_hi = 7'(draft_hi * 10 + k);
                        end
                        if (digit_idx + 1 < trac_pkg::TOTAL_DIGITS) begin
                            digit_idx++;
                        end else begin
                            // Last digit: check the range, then commit or flag
                            keying = 1'b0;
                            digit_idx = 2'd0;
                            if (draft_hi > max_deg || draft_lo > max_deg) begin
                                err_code = trac_pkg::ERR_BOUND;
                            end else if (draft_lo >= draft_hi) begin
                                err_code = trac_pkg::ERR_ORDER;
                            end else begin
                                lo_deg = draft_lo;
                                hi_deg = draft_hi;
                                snooze_pending = 1'b0;
                                err_code = trac_pkg::ERR_NONE;
                            end
                            if (err_code != trac_pkg::ERR_NONE) begin
                                err_timer = hold_len;
                                if (err_timer == 0) err_code = trac_pkg::ERR_NONE;
                            end else begin
                                err_timer = 16'd0;
                            end
                        end
                    end
                end else if (k == trac_pkg::KEY_D) begin
                    keying = 1'b1;
                    digit_idx = 2'd0;
                    draft_lo = 7'd0;
                    draft_hi = 7'd0;
                    err_code = trac_pkg::ERR_NONE;
                    err_timer = 16'd0;
                end else if (k == trac_pkg::KEY_C && buzzing()) begin
                    snooze_pending = 1'b1;
                end
            end
            trac_pkg::KIND_TEMP: temp_now = w.temperature;
            default: ;
        endcase

        // Cycle boundary: start a snooze if one is pending, else a beep cycle
        if (!beeping && snooze_timer == 0 && temp_outside()) begin
            started = 1'b0;
            if (snooze_pending) begin
                snooze_timer = snooze_len;
                if (snooze_timer != 0) started = 1'b1;
                else snooze_pending = 1'b0;
            end
            if (!started) begin
                beeping = 1'b1;
                beep_phase = 17'd0;
            end
        end

        r.buzzer_on      = buzzing();
        r.range_low      = lo_deg;
        r.range_high     = hi_deg;
        r.entering       = keying;
        r.digits_entered = digit_idx;
        r.error_code     = err_code;
        r.error_showing  = (err_timer != 0);
        r.snoozed        = (snooze_timer != 0);
        r.out_of_range   = temp_outside();
        r.temp_shown     = temp_now;
        return r;
    endfunction

    // Word builders; fields the block ignores carry random filler
    function automatic trac_pkg::in_t make_word(input logic [1:0] kind,
                                                input logic [1:0] row,
                                                input logic [1:0] col,
                                                input logic [6:0] deg);
        trac_pkg::in_t w;
        w.kind        = kind;
        w.key_row     = row;
        w.key_col     = col;
        w.temperature = deg;
        return w;
    endfunction

    function automatic trac_pkg::in_t tick_word();
        return make_word(trac_pkg::KIND_TICK, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 7'($urandom_range(0, 99)));
    endfunction

    function automatic trac_pkg::in_t key_word(input logic [1:0] row, input logic [1:0] col);
        return make_word(trac_pkg::KIND_KEY, row, col, 7'($urandom_range(0, 99)));
    endfunction

    function automatic trac_pkg::in_t temp_word(input int deg);
        return make_word(trac_pkg::KIND_TEMP, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 7'(deg));
    endfunction

    function automatic trac_pkg::in_t digit_word(input int d);
        if (d == 0) return key_word(2'd3, 2'd1);
        return key_word(2'((d - 1) / 3), 2'((d - 1) % 3));
    endfunction

    // Letters, star and hash: never digits
    function automatic trac_pkg::in_t stray_key();
        case ($urandom_range(0, 5))
            0: return key_word(2'd0, 2'd3);
            1: return key_word(2'd1, 2'd3);
            2: return key_word(2'd2, 2'd3);
            3: return key_word(2'd3, 2'd3);
            4: return key_word(2'd3, 2'd0);
            default: return key_word(2'd3, 2'd2);
        endcase
    endfunction

    // Temperatures lean toward the extremes and the edges of the range
    function automatic int pick_temp();
        int t;
        case ($urandom_range(0, 3))
            0: t = $urandom_range(0, 1) ? 0 : 99;
            1: t = $urandom_range(0, 99);
            default: begin
                t = ($urandom_range(0, 1) ? gen_lo : gen_hi) + $urandom_range(0, 2) - 1;
                if (t < 0) t = 0;
                if (t > 99) t = 99;
            end
        endcase
        return t;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic stage(input trac_pkg::in_t w, inout int staged);
        word_backlog.push_back(w);
        staged++;
    endtask

    // Key D, four digits, with stray keys and ticks mixed in when noisy
    task automatic queue_entry(input int lo, input int hi, input bit noisy, inout int staged);
        int d;
        stage(key_word(2'd3, 2'd3), staged);
        for (int i = 0; i < trac_pkg::TOTAL_DIGITS; i++) begin
            case (i)
                0: d = lo / 10;
                1: d = lo % 10;
                2: d = hi / 10;
                default: d = hi % 10;
            endcase
            if (noisy && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1)) word_backlog.push_back(stray_key());
                else stage(tick_word(), staged);
            end
            stage(digit_word(d), staged);
        end
    endtask

    task automatic build_phase(input int target);
        int staged, pick, lo, hi, n, m;
        staged = 0;
        m = int'(max_deg);
        while (staged < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
                repeat (n) stage(tick_word(), staged);
            end else if (pick < 45) begin
                stage(temp_word(pick_temp()), staged);
            end else if (pick < 70) begin
                n = $urandom_range(0, 9);
                if (n < 6 && m > 0) begin
                    lo = $urandom_range(0, m - 1);
                    hi = $urandom_range(lo + 1, m);
                    gen_lo = lo;
                    gen_hi = hi;
                end else if (n < 8 && m < 99) begin
                    if ($urandom_range(0, 1)) begin
                        lo = $urandom_range(0, 99);
                        hi = $urandom_range(m + 1, 99);
                    end else begin
                        lo = $urandom_range(m + 1, 99);
                        hi = $urandom_range(0, 99);
                    end
                end else begin
                    lo = $urandom_range(0, m);
                    hi = $urandom_range(0, lo);
                end
                queue_entry(lo, hi, $urandom_range(0, 2) == 0, staged);
            end else if (pick < 78) begin
                stage(key_word(2'd2, 2'd3), staged);
            end else if (pick < 90) begin
                word_backlog.push_back(key_word(2'($urandom_range(0, 3)),
                                                2'($urandom_range(0, 3))));
            end else begin
                // Broken entry: key D and too few digits
                stage(key_word(2'd3, 2'd3), staged);
                repeat ($urandom_range(1, 3)) stage(digit_word($urandom_range(0, 9)), staged);
            end
        end
    endtask

    // Offer one word and hold it until the block takes it
    task automatic offer_word(input trac_pkg::in_t w, input logic typed,
                              input trac_pkg::out_t want);
        int gap;
        gap = (sender_steady || squeeze_req) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= w;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop the input and wait for every status word to come back
    task automatic settle();
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four registers back to back, mirroring each into the model
    task automatic load_settings(input trac_pkg::cfg_t c);
        logic [1:0]  idx;
        logic [15:0] v;
        for (int i = 0; i < 4; i++) begin
            idx = 2'(i);
            case (idx)
                trac_pkg::CFG_BEEP_HALF:  v = c.beep_half_ticks;
                trac_pkg::CFG_SNOOZE:     v = c.snooze_ticks;
                trac_pkg::CFG_ERROR_HOLD: v = c.error_hold_ticks;
                default:                  v = {9'd0, c.max_bound};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v;
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                trac_pkg::CFG_BEEP_HALF:  half_ticks = v;
                trac_pkg::CFG_SNOOZE:     snooze_len = v;
                trac_pkg::CFG_ERROR_HOLD: hold_len = v;
                default:                  max_deg = v[6:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: ready in runs, short and long stalls, one forced hold-off
    initial begin
        int span;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (squeeze_req) begin
                m_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeeze_req = 1'b0;
                squeezes++;
            end else begin
                m_ready <= 1'b1;
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
                repeat (span) @(posedge aclk);
                span = pick_gap();
                if (span > 0) begin
                    m_ready <= 1'b0;
                    repeat (span) @(posedge aclk);
                end
            end
        end
    end

    // Check each status word against the oldest expectation, then predict
    always @(posedge aclk) begin : track_status
        trac_pkg::out_t want;
        trac_pkg::out_t got;
        string bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (status_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("status word %h with nothing expected", got);
                end else begin
                    want = status_due.pop_front();
                    bad = "";
                    if (got.buzzer_on !== want.buzzer_on)
                        bad = {bad, $sformatf(" buzzer_on %0d/%0d", want.buzzer_on,
                                              got.buzzer_on)};
                    if (got.range_low !== want.range_low)
                        bad = {bad, $sformatf(" range_low %0d/%0d", want.range_low,
                                              got.range_low)};
                    if (got.range_high !== want.range_high)
                        bad = {bad, $sformatf(" range_high %0d/%0d", want.range_high,
                                              got.range_high)};
                    if (got.entering !== want.entering)
                        bad = {bad, $sformatf(" entering %0d/%0d", want.entering,
                                              got.entering)};
                    if (got.digits_entered !== want.digits_entered)
                        bad = {bad, $sformatf(" digits_entered %0d/%0d", want.digits_entered,
                                              got.digits_entered)};
                    if (got.error_code !== want.error_code)
                        bad = {bad, $sformatf(" error_code %0d/%0d", want.error_code,
                                              got.error_code)};
                    if (got.error_showing !== want.error_showing)
                        bad = {bad, $sformatf(" error_showing %0d/%0d", want.error_showing,
                                              got.error_showing)};
                    if (got.snoozed !== want.snoozed)
                        bad = {bad, $sformatf(" snoozed %0d/%0d", want.snoozed, got.snoozed)};
                    if (got.out_of_range !== want.out_of_range)
                        bad = {bad, $sformatf(" out_of_range %0d/%0d", want.out_of_range,
                                              got.out_of_range)};
                    if (got.temp_shown !== want.temp_shown)
                        bad = {bad, $sformatf(" temp_shown %0d/%0d", want.temp_shown,
                                              got.temp_shown)};
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("status word %0d mismatch (expected/actual):%s",
                                     words_checked, bad);
                    end
                    words_checked++;
                    if (got.buzzer_on) buzz_seen++;
                    if (got.snoozed) snooze_seen++;
                    if (got.out_of_range) outside_seen++;
                    if (got.error_code == trac_pkg::ERR_BOUND) bound_err_seen++;
                    if (got.error_code == trac_pkg::ERR_ORDER) order_err_seen++;
                end
            end
            if (s_valid && s_ready) begin
                want = predict_status(s_data);
                status_due.push_back(cur_typed ? cur_want : want);
            end
        end
    end

    // Give up when no channel has moved a word for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles", STALL_LIMIT);
                $display("temp_range_alarm_controller_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cur_typed <= 1'b0;
        cur_want  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= trac_pkg::CFG_BEEP_HALF;
        cfg_data  <= '0;
        status_reset();

        // Defaults: range 10..35, max 50, hold 500
        directed_plan = '{
            '{'{trac_pkg::KIND_TEMP, 2'd0, 2'd0, 7'd25}, 1'b1, RESET_VIEW},
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd3, 7'd0},  1'b1, KEYING_VIEW},    // D
            '{'{trac_pkg::KIND_KEY,  2'd0, 2'd3, 7'd0},  1'b1, KEYING_VIEW},    // A ignored
            '{'{trac_pkg::KIND_KEY,  2'd2, 2'd2, 7'd0},  1'b0, '0},   // 9
            '{'{trac_pkg::KIND_KEY,  2'd2, 2'd2, 7'd0},  1'b0, '0},   // 9
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd1, 7'd0},  1'b0, '0},   // 0
            '{'{trac_pkg::KIND_KEY,  2'd0, 2'd0, 7'd0},  1'b1, BOUND_ERR_VIEW}, // 1: 99 > max
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd3, 7'd0},  1'b1, KEYING_VIEW},    // D clears
            '{'{trac_pkg::KIND_KEY,  2'd0, 2'd2, 7'd0},  1'b0, '0},   // 3
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd1, 7'd0},  1'b0, '0},   // 0
            '{'{trac_pkg::KIND_KEY,  2'd0, 2'd1, 7'd0},  1'b0, '0},   // 2
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd1, 7'd0},  1'b1, ORDER_ERR_VIEW}, // 0: 30 >= 20
            '{'{trac_pkg::KIND_TICK, 2'd0, 2'd0, 7'd0},  1'b0, '0},
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd3, 7'd0},  1'b0, '0},   // D
            '{'{trac_pkg::KIND_KEY,  2'd0, 2'd0, 7'd0},  1'b0, '0},   // 1
            '{'{trac_pkg::KIND_KEY,  2'd1, 2'd1, 7'd0},  1'b0, '0},   // 5
            '{'{trac_pkg::KIND_KEY,  2'd1, 2'd0, 7'd0},  1'b0, '0},   // 4
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd1, 7'd0},  1'b0, '0},   // 0: commit 15..40
            '{'{trac_pkg::KIND_TEMP, 2'd3, 2'd3, 7'd99}, 1'b0, '0},   // hot, beep starts
            '{'{trac_pkg::KIND_KEY,  2'd2, 2'd3, 7'd0},  1'b0, '0},   // C while sounding
            '{'{trac_pkg::KIND_KEY,  2'd3, 2'd0, 7'd0},  1'b0, '0},   // star ignored
            '{'{trac_pkg::KIND_TICK, 2'd3, 2'd3, 7'd127}, 1'b0, '0},
            '{'{trac_pkg::KIND_TEMP, 2'd0, 2'd0, 7'd0},  1'b0, '0},   // cold
            '{'{trac_pkg::KIND_TEMP, 2'd0, 2'd0, 7'd40}, 1'b0, '0},   // upper edge
            '{'{trac_pkg::KIND_KEY,  2'd2, 2'd1, 7'd0},  1'b0, '0}    // 8 ignored idle
        };

        // beep half, snooze, error hold, max bound
        phase_cfg = '{
            '{16'd1,     16'd1,     16'd1,     7'd99},
            '{16'd3,     16'd12,    16'd5,     7'd50},
            '{16'd65535, 16'd65535, 16'd65535, 7'd0},
            '{16'd2,     16'd4,     16'd2,     7'd75},
            '{16'd5,     16'd20,    16'd9,     7'd99}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_settings(phase_cfg[p]);
            sender_steady = (p == 1);
            if (p == 3) squeeze_req = 1'b1;
            build_phase(PHASE_WORDS);
            while (word_backlog.size() != 0) offer_word(word_backlog.pop_front(), 1'b0, '0);
        end

        settle();
        repeat (10) @(posedge aclk);
        mismatches += status_due.size();

        $display("checked %0d status words over %0d settings: %0d buzzing, %0d snoozed,",
                 words_checked, PHASES + 1, buzz_seen, snooze_seen);
        $display("%0d out of range; entry errors shown: %0d bound, %0d order;",
                 outside_seen, bound_err_seen, order_err_seen);
        $display("%0d long result hold-off(s); %0d mismatches", squeezes, mismatches);
        if (mismatches == 0) begin
            $display("temp_range_alarm_controller_unit test passed");
        end else begin
            $display("temp_range_alarm_controller_unit test failed");
        end
        $finish;
    end

endmodule
